// File: hw/rtl/motor_rumble_ramp_envelope_top_assert.svh
// ----------------------------------------------------------------------------
// Rumble envelope assertion macros
// Shared concurrent assertion forms for the rumble envelope RTL.
// ----------------------------------------------------------------------------
`ifndef MOTOR_RUMBLE_RAMP_ENVELOPE_TOP_ASSERT_SVH
`define MOTOR_RUMBLE_RAMP_ENVELOPE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MRE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mre_pkg.sv
// ----------------------------------------------------------------------------
// Rumble envelope package
// Widths, codes and shared types of the rumble envelope generator.
// ----------------------------------------------------------------------------
package mre_pkg;

    localparam int TIME_W    = 48;
    localparam int LEN_W     = 32;
    localparam int LVL_W     = 8;
    localparam int PERIOD_W  = 24;
    localparam int NUM_W     = LVL_W + LEN_W + 1;
    localparam int PROD_W    = LVL_W + LEN_W;
    localparam int DIV_STEPS = LVL_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd50000;
    localparam logic [LVL_W-1:0]    LVL_MAX      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_MOUNTED = 1'b0,
        CFG_UPDATE_PERIOD  = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        CMD_TICK    = 1'b0,
        CMD_VIBRATE = 1'b1
    } cmd_t;

    typedef enum logic [0:0] {
        CAUSE_REFRESH = 1'b0,
        CAUSE_VIBRATE = 1'b1
    } cause_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                mounted;
        logic [PERIOD_W-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [LVL_W-1:0] quo;
    } div_res_t;

endpackage

// File: hw/rtl/mre_cmd_if.sv
// ----------------------------------------------------------------------------
// Rumble command channel
// Valid/ready channel carrying tick and vibrate items.
// ----------------------------------------------------------------------------
interface mre_cmd_if import mre_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [TIME_W-1:0]       time_us;
    logic [LVL_W-1:0]        start_level;
    logic signed [LVL_W-1:0] slope;
    logic [LEN_W-1:0]        duration_us;

    modport source (
        output valid, command, time_us, start_level, slope, duration_us,
        input  ready
    );

    modport sink (
        input  valid, command, time_us, start_level, slope, duration_us,
        output ready
    );

endinterface

// File: hw/rtl/mre_lvl_if.sv
// ----------------------------------------------------------------------------
// Rumble level channel
// Valid/ready channel carrying motor level results.
// ----------------------------------------------------------------------------
interface mre_lvl_if import mre_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] motor_level;
    logic             cause;

    modport source (
        output valid, motor_level, cause,
        input  ready
    );

    modport sink (
        input  valid, motor_level, cause,
        output ready
    );

endinterface

// File: hw/rtl/mre_cfg_if.sv
// ----------------------------------------------------------------------------
// Rumble configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mre_cfg_if import mre_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

// File: hw/rtl/motor_rumble_ramp_envelope_top.sv
// ----------------------------------------------------------------------------
// Rumble envelope generator
// Tracks a linear rumble ramp per vibrate command and emits motor levels on
// vibrate start and on periodic refresh ticks.
// ----------------------------------------------------------------------------
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------
//   cmd_ch   | in  | command, time_us, start_level, slope, duration_us
//   lvl_ch   | out | motor_level, cause
//   cfg_ch   | in  | index (0 mount flag, 1 update period), data
//
// One item at a time: accept, evaluate, then for a ramp tick a multiply step,
// the serial divide and a finish step; a result then goes through the emit
// state. The next beat is taken only once the block is back in idle.
// rst_n clears control state asynchronously: stopped, level zero, period 50000.
// A held result does not block the next beat; only the hand-off into a
// still-full output register waits for lvl_ch.ready.
// ----------------------------------------------------------------------------
`include "motor_rumble_ramp_envelope_top_assert.svh"

module motor_rumble_ramp_envelope_top import mre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mre_cmd_if.sink    cmd_ch,
    mre_lvl_if.source  lvl_ch,
    mre_cfg_if.sink    cfg_ch
);

    cfg_t     cfg;
    div_res_t div_res;

    state_t state_reg, state_next;

    // Latched input beat.
    cmd_t                    cmd_reg;
    logic [TIME_W-1:0]       t_reg;
    logic [LVL_W-1:0]        start_reg;
    logic signed [LVL_W-1:0] slope_reg;
    logic [LEN_W-1:0]        dur_reg;

    // Envelope state.
    logic [TIME_W-1:0] now_reg,  now_next;
    logic [TIME_W-1:0] stop_reg, stop_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic [LVL_W-1:0]  base_reg, base_next;
    logic              neg_reg,  neg_next;
    logic              nz_reg,   nz_next;
    logic              stopped_reg, stopped_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    // Per-tick working values.
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              due_reg, due_next;
    cause_t            cause_reg, cause_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  out_level_reg, out_level_next;
    cause_t            out_cause_reg, out_cause_next;

    logic              accept;
    logic [TIME_W-1:0] to_stop;
    logic [TIME_W-1:0] since_emit;
    logic              due_now;
    logic [LVL_W-1:0]  span;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;
    logic              div_start;

    mre_cfg u_cfg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    mre_serdiv u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .len   (len_reg),
        .res   (div_res)
    );

    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    // Time arithmetic wraps at the time width.
    assign to_stop    = stop_reg - t_reg;
    assign since_emit = t_reg - last_reg;
    assign due_now    = since_emit > TIME_W'(cfg.period);

    // Rounded scale numerator: 2*span*rem + len.
    assign span = neg_reg ? base_reg : (LVL_MAX - base_reg);
    assign prod = PROD_W'(span) * PROD_W'(rem_reg);
    assign num  = {prod, 1'b0} + NUM_W'(len_reg);

    assign lvl_ch.valid       = out_valid_reg;
    assign lvl_ch.motor_level = out_level_reg;
    assign lvl_ch.cause       = out_cause_reg;

    // Hold the accepted beat for the evaluation steps.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(cmd_ch.command);
            t_reg     <= cmd_ch.time_us;
            start_reg <= cmd_ch.start_level;
            slope_reg <= cmd_ch.slope;
            dur_reg   <= cmd_ch.duration_us;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        stop_next      = stop_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        nz_next        = nz_reg;
        stopped_next   = stopped_reg;
        level_next     = level_reg;
        rem_next       = rem_reg;
        due_next       = due_reg;
        cause_next     = cause_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_cause_next = out_cause_reg;
        div_start      = 1'b0;

        // Drop the output beat once the sink takes it.
        if (out_valid_reg && lvl_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (cmd_reg == CMD_VIBRATE)
                begin
                    if (cfg.mounted)
                    begin
                        // Arm a new ramp and report the start level at once.
                        len_next     = dur_reg;
                        stop_next    = now_reg + TIME_W'(dur_reg);
                        neg_next     = slope_reg[LVL_W-1];
                        nz_next      = (slope_reg != '0);
                        base_next    = start_reg;
                        stopped_next = 1'b0;
                        level_next   = start_reg;
                        last_next    = now_reg;
                        cause_next   = CAUSE_VIBRATE;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Tick: time always advances, even while unmounted.
                    now_next   = t_reg;
                    rem_next   = to_stop[LEN_W-1:0];
                    due_next   = due_now;
                    cause_next = CAUSE_REFRESH;
                    if (!cfg.mounted)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!stopped_reg && nz_reg && (len_reg != '0)
                             && (t_reg < stop_reg))
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        // Stop time reached: drop to zero and stop the ramp.
                        if (!stopped_reg && (t_reg >= stop_reg))
                        begin
                            stopped_next = 1'b1;
                            level_next   = '0;
                        end
                        if (due_now)
                        begin
                            last_next  = t_reg;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_res.done)
                begin
                    // Saturate a quotient past full scale.
                    if (neg_reg)
                    begin
                        level_next = div_res.sat ? LVL_MAX : div_res.quo;
                    end
                    else
                    begin
                        level_next = div_res.sat ? '0 : (LVL_MAX - div_res.quo);
                    end
                    if (due_reg)
                    begin
                        last_next  = t_reg;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                // Load the output register once it is free.
                if (!out_valid_reg || lvl_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_reg;
                    out_cause_next = cause_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            stop_reg      <= '0;
            last_reg      <= '0;
            base_reg      <= '0;
            neg_reg       <= 1'b0;
            nz_reg        <= 1'b0;
            stopped_reg   <= 1'b1;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            stop_reg      <= stop_next;
            last_reg      <= last_next;
            base_reg      <= base_next;
            neg_reg       <= neg_next;
            nz_reg        <= nz_next;
            stopped_reg   <= stopped_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        rem_reg       <= rem_next;
        due_reg       <= due_next;
        cause_reg     <= cause_next;
        out_level_reg <= out_level_next;
        out_cause_reg <= out_cause_next;
    end

    `MRE_ASSERT_IMP(a_stopped_level_zero, clk, rst_n, stopped_reg, level_reg == '0, "nonzero level while stopped")
    `MRE_ASSERT_IMP(a_div_len_nonzero, clk, rst_n, state_reg == ST_DIV, len_reg != '0, "divide by zero length")
    `MRE_ASSERT_IMP(a_done_in_div, clk, rst_n, div_res.done, state_reg == ST_DIV, "divider result outside divide state")

endmodule

// File: hw/rtl/mre_cfg.sv
// ----------------------------------------------------------------------------
// Rumble configuration registers
// Holds the mount flag and the refresh period written over the config channel.
// ----------------------------------------------------------------------------
module mre_cfg import mre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mre_cfg_if.sink      cfg_ch,
    output cfg_t         cfg
);

    logic                mounted_reg;
    logic [PERIOD_W-1:0] period_reg;

    // Writes must arrive only while the block is idle; not enforced here, never stalled.
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mounted_reg <= 1'b0;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_reg_t'(cfg_ch.index))
                CFG_DEVICE_MOUNTED: mounted_reg <= cfg_ch.data[0];
                CFG_UPDATE_PERIOD:  period_reg  <= cfg_ch.data[PERIOD_W-1:0];
            endcase
        end
    end

    assign cfg.mounted = mounted_reg;
    assign cfg.period  = period_reg;

endmodule

// File: hw/rtl/mre_serdiv.sv
// ----------------------------------------------------------------------------
// Rumble serial divider
// Restoring divider, one quotient bit per cycle; top bit flags saturation.
// ----------------------------------------------------------------------------
`include "motor_rumble_ramp_envelope_top_assert.svh"

module mre_serdiv import mre_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [LEN_W-1:0] len,
    output div_res_t         res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     dvs_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [NUM_W:0]       diff;
    logic                 take;

    // Trial subtract of the shifted divisor.
    assign diff = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign take = !diff[NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Divisor is 2*len, aligned to the saturation bit at the start.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dvs_reg <= {len, 1'b0, {LVL_W{1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_reg <= diff[NUM_W-1:0];
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[DIV_STEPS-2:0], take};
        end
    end

    assign res.done = done_reg;
    assign res.sat  = quo_reg[DIV_STEPS-1];
    assign res.quo  = quo_reg[LVL_W-1:0];

    `MRE_ASSERT_IMP(a_start_when_free, clk, rst_n, start, !busy_reg, "divider restarted while busy")
    `MRE_ASSERT_IMP(a_busy_count, clk, rst_n, busy_reg, cnt_reg != '0, "busy divider with no steps left")
    `MRE_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg && !busy_reg, "done held past one cycle")

endmodule

// File: tb/rumble_level_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rumble level monitor
// Watches the command, level and register channels of the rumble envelope
// generator. Tracks the envelope state, predicts each motor level beat and
// compares the beats that come out against those predictions in order.
// ----------------------------------------------------------------------------
module rumble_level_monitor import mre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mre_cmd_if   cmd_ch,
    mre_lvl_if   lvl_ch,
    mre_cfg_if   cfg_ch,
    output int   pending,
    output int   fail_count
);

    typedef struct packed {
        logic [LVL_W-1:0] level;
        cause_t           cause;
    } level_beat_t;

    level_beat_t due_levels[$];

    // Shadow of the envelope state and the registers
    logic [TIME_W-1:0]       now_t;
    logic [TIME_W-1:0]       stop_t;
    logic [TIME_W-1:0]       last_emit_t;
    logic [LEN_W-1:0]        ramp_len;
    logic [LVL_W-1:0]        base_lvl;
    logic [LVL_W-1:0]        cur_lvl;
    logic signed [LVL_W-1:0] ramp_dir;
    logic                    halted;
    logic                    mounted;
    logic [PERIOD_W-1:0]     period;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void push_level(logic [LVL_W-1:0] lvl, cause_t why);
        level_beat_t b;
        b.level = lvl;
        b.cause = why;
        due_levels.push_back(b);
    endfunction

    // Advance the envelope by one command beat; queue the level it emits.
    function automatic void advance_envelope(cmd_t c, logic [TIME_W-1:0] t,
                                             logic [LVL_W-1:0] lvl,
                                             logic signed [LVL_W-1:0] dir,
                                             logic [LEN_W-1:0] dur);
        logic [LEN_W-1:0]  rem;
        logic [63:0]       span;
        logic [63:0]       q;
        logic [TIME_W-1:0] since;
        if (c == CMD_VIBRATE) begin
            if (!mounted)
                return;
            ramp_len    = dur;
            stop_t      = now_t + dur;
            ramp_dir    = dir;
            base_lvl    = lvl;
            halted      = 1'b0;
            cur_lvl     = lvl;
            last_emit_t = now_t;
            push_level(cur_lvl, CAUSE_VIBRATE);
            return;
        end
        now_t = t;
        if (!mounted)
            return;
        if (!halted) begin
            if (t >= stop_t) begin
                halted  = 1'b1;
                cur_lvl = '0;
            end else if (ramp_dir != 0 && ramp_len != 0) begin
                rem  = stop_t[LEN_W-1:0] - t[LEN_W-1:0];
                span = (ramp_dir < 0) ? 64'(base_lvl) : 64'(LVL_MAX - base_lvl);
                q    = (span * 64'(rem) * 2 + 64'(ramp_len)) / (64'(ramp_len) * 2);
                if (ramp_dir < 0)
                    cur_lvl = (q > 255) ? LVL_MAX : q[LVL_W-1:0];
                else
                    cur_lvl = (q > 255) ? '0 : LVL_MAX - q[LVL_W-1:0];
            end
        end
        since = t - last_emit_t;
        if (since > TIME_W'(period)) begin
            last_emit_t = t;
            push_level(cur_lvl, CAUSE_REFRESH);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        level_beat_t head;
        if (!rst_n) begin
            now_t       = '0;
            stop_t      = '0;
            last_emit_t = '0;
            ramp_len    = '0;
            base_lvl    = '0;
            cur_lvl     = '0;
            ramp_dir    = '0;
            halted      = 1'b1;
            mounted     = 1'b0;
            period      = PERIOD_RESET;
            fail_count  = 0;
            due_levels.delete();
            pending    <= 0;
        end else begin
            // Check the outgoing beat first: it can only stem from earlier commands
            if (lvl_ch.valid && lvl_ch.ready) begin
                if (due_levels.size() == 0) begin
                    report_mismatch($sformatf("unexpected level beat %0d cause %0d",
                                              lvl_ch.motor_level, lvl_ch.cause));
                end else begin
                    head = due_levels.pop_front();
                    if (lvl_ch.motor_level !== head.level)
                        report_mismatch($sformatf("motor_level got %0d want %0d",
                                                  lvl_ch.motor_level, head.level));
                    if (lvl_ch.cause !== head.cause)
                        report_mismatch($sformatf("cause got %0d want %0d",
                                                  lvl_ch.cause, head.cause));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_reg_t'(cfg_ch.index))
                    CFG_DEVICE_MOUNTED: mounted = cfg_ch.data[0];
                    CFG_UPDATE_PERIOD:  period  = cfg_ch.data;
                    default: ;
                endcase
            end
            if (cmd_ch.valid && cmd_ch.ready)
                advance_envelope(cmd_t'(cmd_ch.command), cmd_ch.time_us,
                                 cmd_ch.start_level, cmd_ch.slope, cmd_ch.duration_us);
            pending <= due_levels.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rumble envelope generator testbench
// Drives tick and vibrate beats through the envelope generator under several
// register settings, with bursty input and a stalling level receiver, while
// the level monitor predicts and checks every motor level beat.
// ----------------------------------------------------------------------------
module tb import mre_pkg::*;
();

    localparam int     HALF_NS       = 6;
    localparam int     SETTLE_CYCLES = 32;         // well over the time a ramp tick takes
    localparam longint LIMIT_NS      = 15_000_000;

    typedef enum int {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    mre_cmd_if cmd_ch ();
    mre_lvl_if lvl_ch ();
    mre_cfg_if cfg_ch ();

    int pending;
    int fail_count;

    // Stimulus bookkeeping
    logic [TIME_W-1:0]   sim_us;       // time carried by the latest tick
    logic [PERIOD_W-1:0] cur_period;   // period last written, for refresh jumps
    int                  sent;         // command beats accepted so far
    int                  burst_left;   // beats left in the current input burst
    bit                  tx_gaps;      // insert gaps between bursts
    rx_mode_t            rx_mode;
    int                  stall_left;

    motor_rumble_ramp_envelope_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .lvl_ch (lvl_ch),
        .cfg_ch (cfg_ch)
    );

    rumble_level_monitor u_level_mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ch     (cmd_ch),
        .lvl_ch     (lvl_ch),
        .cfg_ch     (cfg_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always
    begin
        #(HALF_NS) clk = 1'b1;
        #(HALF_NS) clk = 1'b0;
    end

    // Level receiver: stall in runs of random length; how often depends on mode
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left   <= 0;
            lvl_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            lvl_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_LIGHT:
                    if ($urandom_range(0, 9) == 0)
                    begin
                        stall_left   <= $urandom_range(0, 3);
                        lvl_ch.ready <= 1'b0;
                    end
                    else
                        lvl_ch.ready <= 1'b1;
                RX_HEAVY:
                    if ($urandom_range(0, 2) == 0)
                    begin
                        stall_left   <= $urandom_range(0, 12);
                        lvl_ch.ready <= 1'b0;
                    end
                    else
                        lvl_ch.ready <= 1'b1;
                default:
                    lvl_ch.ready <= 1'b1;
            endcase
        end
    end

    // Send one command beat and hold it until accepted. Between bursts, with gaps
    // on, drop valid for a random gap; within a burst, keep valid high across beats.
    task automatic send_beat(input cmd_t c, input logic [TIME_W-1:0] t,
                             input logic [LVL_W-1:0] lvl,
                             input logic signed [LVL_W-1:0] dir,
                             input logic [LEN_W-1:0] dur);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (tx_gaps)
            begin
                gap = $urandom_range(1, 8);
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c;
        cmd_ch.time_us     <= t;
        cmd_ch.start_level <= lvl;
        cmd_ch.slope       <= dir;
        cmd_ch.duration_us <= dur;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        sent++;
    endtask

    // Unused fields of each beat carry random values to exercise their bits
    task automatic send_tick(input logic [TIME_W-1:0] t);
        sim_us = t;
        send_beat(CMD_TICK, t, LVL_W'($urandom()), LVL_W'($urandom()),
                  LEN_W'($urandom()));
    endtask

    task automatic send_vibrate(input logic [LVL_W-1:0] lvl,
                                input logic signed [LVL_W-1:0] dir,
                                input logic [LEN_W-1:0] dur);
        send_beat(CMD_VIBRATE, TIME_W'({$urandom(), $urandom()}), lvl, dir, dur);
    endtask

    // Drop valid and hold off until every predicted level has come out, then
    // let the block settle since ticks without a level may still be in flight.
    task automatic drain_levels();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One vibrate followed by a run of ticks that walk the ramp toward, and
    // often past, its stop time.
    task automatic ramp_episode();
        logic [LEN_W-1:0]        dur;
        logic signed [LVL_W-1:0] dir;
        logic [TIME_W-1:0]       step;
        int                      n;
        // now and then start just below the top of the time range
        if ($urandom_range(0, 39) == 0)
            send_tick('1 - TIME_W'($urandom_range(0, 5000)));
        case ($urandom_range(0, 19))
            0:       dur = '0;
            1:       dur = LEN_W'($urandom());
            2, 3:    dur = LEN_W'($urandom_range(1, 16));
            default: dur = LEN_W'($urandom_range(1, 4000));
        endcase
        case ($urandom_range(0, 7))
            0:       dir = '0;
            1:       dir = 8'sh80;
            2:       dir = 8'sh7f;
            default: dir = LVL_W'($urandom());
        endcase
        send_vibrate(LVL_W'($urandom_range(0, 255)), dir, dur);
        n    = $urandom_range(1, 10);
        step = TIME_W'(dur) / TIME_W'(n);
        repeat (n)
        begin
            case ($urandom_range(0, 19))
                0:       sim_us = sim_us - TIME_W'($urandom_range(1, 3000));
                1:       sim_us = sim_us + TIME_W'(dur) + TIME_W'($urandom_range(0, 50));
                default: sim_us = sim_us + step * TIME_W'($urandom_range(0, 200))
                                  / TIME_W'(100);
            endcase
            send_tick(sim_us);
        end
        // refresh jump right at or just past the update period
        if ($urandom_range(0, 2) == 0)
            send_tick(sim_us + TIME_W'(cur_period) + TIME_W'($urandom_range(0, 2)));
    endtask

    task automatic noise_beat();
        if ($urandom_range(0, 1) == 0)
            send_tick(TIME_W'({$urandom(), $urandom()}));
        else
            send_vibrate(LVL_W'($urandom()), LVL_W'($urandom()), LEN_W'($urandom()));
    endtask

    // Reprogram both registers while idle, then run random traffic
    task automatic run_phase(input bit mount, input logic [PERIOD_W-1:0] per,
                             input rx_mode_t rx, input bit gaps, input int n_beats);
        int phase_end;
        drain_levels();
        write_reg(CFG_DEVICE_MOUNTED, CFG_DAT_W'(mount));
        write_reg(CFG_UPDATE_PERIOD, per);
        cur_period = per;
        rx_mode   <= rx;
        tx_gaps    = gaps;
        phase_end  = sent + n_beats;
        while (sent < phase_end)
        begin
            if ($urandom_range(0, 9) == 0)
                noise_beat();
            else
                ramp_episode();
            // occasionally hold off until the level queue runs dry
            if ($urandom_range(0, 149) == 0)
                drain_levels();
        end
    endtask

    // Hard stop in case the block hangs or a level never arrives
    initial
    begin
        #(LIMIT_NS);
        $display("motor_rumble_ramp_envelope_top test failed");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_TICK;
        cmd_ch.time_us     <= '0;
        cmd_ch.start_level <= '0;
        cmd_ch.slope       <= '0;
        cmd_ch.duration_us <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_DEVICE_MOUNTED;
        cfg_ch.data        <= '0;
        rx_mode            <= RX_STEADY;
        sim_us     = '0;
        cur_period = PERIOD_RESET;
        sent       = 0;
        burst_left = 0;
        tx_gaps    = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: unmounted beats change nothing but the time
        send_tick(48'd1000);
        send_vibrate(8'd200, -8'sd5, 32'd500);

        // Period zero: every tick at a new time refreshes
        drain_levels();
        write_reg(CFG_DEVICE_MOUNTED, CFG_DAT_W'(1));
        write_reg(CFG_UPDATE_PERIOD, '0);
        cur_period = '0;
        rx_mode   <= RX_LIGHT;
        tx_gaps    = 1'b1;

        // falling ramp from full scale to the stop time, with a half-way tie
        send_vibrate(8'd255, 8'sh80, 32'd1000);
        send_tick(48'd1250);
        send_tick(48'd1500);
        send_tick(48'd1999);
        send_tick(48'd2000);
        // rising ramp from zero, then time going backwards saturates it to zero
        send_vibrate(8'd0, 8'sh7f, 32'd1000);
        send_tick(48'd2500);
        send_tick(48'd1500);
        // falling ramp with time going backwards saturates to full scale
        send_vibrate(8'd200, -8'sd1, 32'd100);
        send_tick(48'd1000);
        // zero slope holds the start level
        send_vibrate(8'd77, 8'sd0, 32'd500);
        send_tick(48'd1200);
        // zero ramp length: level frozen until the stop time is reached
        send_vibrate(8'd90, 8'sd5, 32'd0);
        send_tick(48'd1100);
        send_tick(48'd1200);
        // stop time wrapping past the top of the range ends on the first tick
        send_tick(48'hFFFF_FFFF_FFF0);
        send_vibrate(8'd128, -8'sd64, 32'h100);
        send_tick('1);
        // longest ramps from the bottom of the time range
        send_tick('0);
        send_vibrate(8'd255, 8'sh7f, '1);
        send_tick(48'h0000_8000_0000);
        send_vibrate(8'd1, 8'sh80, '1);
        send_tick(48'h0000_7FFF_FFFF);
        send_tick(48'h0001_0000_0000);

        // Random phases over the register settings, extremes included
        run_phase(1'b1, '0,                  RX_STEADY, 1'b0, 250);
        run_phase(1'b1, PERIOD_RESET,        RX_HEAVY,  1'b1, 250);
        run_phase(1'b1, '1,                  RX_LIGHT,  1'b1, 250);
        run_phase(1'b0, PERIOD_W'($urandom()), RX_LIGHT, 1'b1, 60);
        run_phase(1'b1, PERIOD_W'($urandom_range(1, 5000)), RX_LIGHT, 1'b1, 400);
        run_phase(1'b1, PERIOD_W'(1),        RX_HEAVY,  1'b1, 250);

        // Wait for the last levels, then give the block time to show strays
        drain_levels();

        if (fail_count == 0 && pending == 0)
            $display("motor_rumble_ramp_envelope_top test passed");
        else
            $display("motor_rumble_ramp_envelope_top test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mre_pkg.sv
hw/rtl/mre_cmd_if.sv
hw/rtl/mre_lvl_if.sv
hw/rtl/mre_cfg_if.sv
hw/rtl/mre_cfg.sv
hw/rtl/mre_serdiv.sv
hw/rtl/motor_rumble_ramp_envelope_top.sv
tb/rumble_level_monitor.sv
tb/tb.sv
